// ===== rtl/tuso_pkg.sv =====
// Shared widths, constants and stage word types for the triangle/unit-square overlap pipeline.
package tuso_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 24;
  localparam int TOL_W     = 16;
  localparam int EDGES     = 3;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int DOT_W     = PROD_W + 1;
  localparam int PROJ_W    = DOT_W + 1;
  localparam int NORM_W    = DIFF_W + 2;
  localparam int CMP_W     = PROJ_W + 2;
  localparam int DATA_W    = 2 * EDGES * COORD_W;
  localparam int OUT_W     = 8;

  typedef logic [EDGES-1:0][COORD_W-1:0] coord_vec_t;
  typedef logic [EDGES-1:0][DIFF_W-1:0]  diff_vec_t;
  typedef logic [EDGES-1:0][PROD_W-1:0]  prod_vec_t;
  typedef logic [EDGES-1:0][DOT_W-1:0]   dot_vec_t;
  typedef logic [EDGES-1:0][PROJ_W-1:0]  proj_vec_t;
  typedef logic [EDGES-1:0][CMP_W-1:0]   cmp_vec_t;

  typedef struct packed {
    logic       coords_ok;
    coord_vec_t pu;
    coord_vec_t pv;
  } tri_t;

  typedef struct packed {
    logic               coords_ok;
    coord_vec_t         pu;
    coord_vec_t         pv;
    diff_vec_t          du;
    diff_vec_t          dv;
    logic [COORD_W-1:0] umin;
    logic [COORD_W-1:0] umax;
    logic [COORD_W-1:0] vmin;
    logic [COORD_W-1:0] vmax;
  } s1_t;

  typedef struct packed {
    logic              ok;
    prod_vec_t         pvdu;
    prod_vec_t         pudv;
    logic [PROD_W-1:0] area_p;
    logic [PROD_W-1:0] area_q;
    diff_vec_t         du;
    diff_vec_t         dv;
  } s2_t;

  typedef struct packed {
    logic             ok;
    dot_vec_t         de;
    logic [DOT_W-1:0] area;
    cmp_vec_t         smin;
    cmp_vec_t         smax;
  } s3_t;

  typedef struct packed {
    logic      ok;
    proj_vec_t de;
    proj_vec_t dopp;
    cmp_vec_t  smin;
    cmp_vec_t  smax;
  } s4_t;

  typedef struct packed {
    logic     ok;
    cmp_vec_t tmin;
    cmp_vec_t tmax;
    cmp_vec_t smin;
    cmp_vec_t smax;
  } s5_t;

endpackage

// ===== rtl/tuso_setup.sv =====
// Stages 1-2: edge differences, axis-aligned bounds, X/Y tests and edge products.
module tuso_setup (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tuso_pkg::tri_t             in_word,
  input  logic [tuso_pkg::TOL_W-1:0] tol,
  output logic                       out_valid,
  input  logic                       out_ready,
  output tuso_pkg::s2_t              out_word
);
  import tuso_pkg::*;

  s1_t  s1, s1_next;
  s2_t  out_word_next;
  logic s1_valid, s1_ready, s2_ready;

  function automatic logic [COORD_W-1:0] smin2(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y);
    return ($signed(x) < $signed(y)) ? x : y;
  endfunction

  function automatic logic [COORD_W-1:0] smax2(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y);
    return ($signed(x) > $signed(y)) ? x : y;
  endfunction

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    int n;
    s1_next.coords_ok = in_word.coords_ok;
    s1_next.pu        = in_word.pu;
    s1_next.pv        = in_word.pv;
    for (int e = 0; e < EDGES; e++) begin
      n = (e == EDGES - 1) ? 0 : e + 1;
      s1_next.du[e] = DIFF_W'($signed(in_word.pu[n])) - DIFF_W'($signed(in_word.pu[e]));
      s1_next.dv[e] = DIFF_W'($signed(in_word.pv[n])) - DIFF_W'($signed(in_word.pv[e]));
    end
    s1_next.umin = smin2(smin2(in_word.pu[0], in_word.pu[1]), in_word.pu[2]);
    s1_next.umax = smax2(smax2(in_word.pu[0], in_word.pu[1]), in_word.pu[2]);
    s1_next.vmin = smin2(smin2(in_word.pv[0], in_word.pv[1]), in_word.pv[2]);
    s1_next.vmax = smax2(smax2(in_word.pv[0], in_word.pv[1]), in_word.pv[2]);
  end

  always_comb begin
    logic signed [CMP_W-1:0] tol_w, one_sq, umin_w, umax_w, vmin_w, vmax_w;
    logic                    sep_x, sep_y;
    tol_w  = CMP_W'(tol);
    one_sq = CMP_W'(1) <<< (2 * FRAC_BITS);
    umin_w = CMP_W'($signed(s1.umin)) <<< FRAC_BITS;
    umax_w = CMP_W'($signed(s1.umax)) <<< FRAC_BITS;
    vmin_w = CMP_W'($signed(s1.vmin)) <<< FRAC_BITS;
    vmax_w = CMP_W'($signed(s1.vmax)) <<< FRAC_BITS;
    sep_x  = (umax_w < -tol_w) || (one_sq < umin_w - tol_w);
    sep_y  = (vmax_w < -tol_w) || (one_sq < vmin_w - tol_w);
    out_word_next.ok = s1.coords_ok && !sep_x && !sep_y;
    for (int e = 0; e < EDGES; e++) begin
      out_word_next.pvdu[e] = PROD_W'($signed(s1.pv[e])) * PROD_W'($signed(s1.du[e]));
      out_word_next.pudv[e] = PROD_W'($signed(s1.pu[e])) * PROD_W'($signed(s1.dv[e]));
    end
    out_word_next.area_p = PROD_W'($signed(s1.dv[0])) * PROD_W'($signed(s1.du[2]));
    out_word_next.area_q = PROD_W'($signed(s1.du[0])) * PROD_W'($signed(s1.dv[2]));
    out_word_next.du     = s1.du;
    out_word_next.dv     = s1.dv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) s1 <= s1_next;
    if (s2_ready && s1_valid) out_word <= out_word_next;
  end

endmodule

// ===== rtl/tuso_project.sv =====
// Stages 3-4: edge-normal projections, doubled area and unit square bounds.
module tuso_project (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tuso_pkg::s2_t in_word,
  output logic          out_valid,
  input  logic          out_ready,
  output tuso_pkg::s4_t out_word
);
  import tuso_pkg::*;

  s3_t  s3, s3_next;
  s4_t  out_word_next;
  logic s3_valid, s3_ready, s4_ready;

  assign s4_ready = !out_valid || out_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign in_ready = s3_ready;

  always_comb begin
    logic signed [NORM_W-1:0] nx, ny, lo, hi;
    s3_next.ok   = in_word.ok;
    s3_next.area = DOT_W'($signed(in_word.area_p)) - DOT_W'($signed(in_word.area_q));
    for (int e = 0; e < EDGES; e++) begin
      s3_next.de[e] = DOT_W'($signed(in_word.pvdu[e])) - DOT_W'($signed(in_word.pudv[e]));
      nx = -NORM_W'($signed(in_word.dv[e]));
      ny = NORM_W'($signed(in_word.du[e]));
      lo = ((nx < 0) ? nx : '0) + ((ny < 0) ? ny : '0);
      hi = ((nx > 0) ? nx : '0) + ((ny > 0) ? ny : '0);
      s3_next.smin[e] = CMP_W'(lo) <<< FRAC_BITS;
      s3_next.smax[e] = CMP_W'(hi) <<< FRAC_BITS;
    end
  end

  always_comb begin
    out_word_next.ok   = s3.ok;
    out_word_next.smin = s3.smin;
    out_word_next.smax = s3.smax;
    for (int e = 0; e < EDGES; e++) begin
      out_word_next.de[e]   = PROJ_W'($signed(s3.de[e]));
      out_word_next.dopp[e] = PROJ_W'($signed(s3.de[e])) + PROJ_W'($signed(s3.area));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s3_ready) s3_valid <= in_valid;
      if (s4_ready) out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && in_valid) s3 <= s3_next;
    if (s4_ready && s3_valid) out_word <= out_word_next;
  end

endmodule

// ===== rtl/tuso_decide.sv =====
// Stages 5-6: triangle interval per edge axis, tolerance compare and result register.
module tuso_decide (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tuso_pkg::s4_t              in_word,
  input  logic [tuso_pkg::TOL_W-1:0] tol,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       overlaps
);
  import tuso_pkg::*;

  s5_t  s5, s5_next;
  logic overlaps_next;
  logic s5_valid, s5_ready, s6_ready;

  assign s6_ready = !out_valid || out_ready;
  assign s5_ready = !s5_valid || s6_ready;
  assign in_ready = s5_ready;

  always_comb begin
    logic signed [CMP_W-1:0] a, b;
    s5_next.ok   = in_word.ok;
    s5_next.smin = in_word.smin;
    s5_next.smax = in_word.smax;
    for (int e = 0; e < EDGES; e++) begin
      a = CMP_W'($signed(in_word.de[e]));
      b = CMP_W'($signed(in_word.dopp[e]));
      s5_next.tmin[e] = (a < b) ? a : b;
      s5_next.tmax[e] = (a < b) ? b : a;
    end
  end

  always_comb begin
    logic signed [CMP_W-1:0] tol_w;
    logic                    sep;
    tol_w = CMP_W'(tol);
    sep   = 1'b0;
    for (int e = 0; e < EDGES; e++) begin
      if (($signed(s5.tmax[e]) < $signed(s5.smin[e]) - tol_w) ||
          ($signed(s5.smax[e]) < $signed(s5.tmin[e]) - tol_w)) begin
        sep = 1'b1;
      end
    end
    overlaps_next = s5.ok && !sep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s5_ready) s5_valid <= in_valid;
      if (s6_ready) out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_ready && in_valid) s5 <= s5_next;
    if (s6_ready && s5_valid) overlaps <= overlaps_next;
  end

endmodule

// ===== rtl/triangle_unit_square_overlap.sv =====
// Top level: triangle versus unit square separating axis test on stream ports.
// Throughput: one word per cycle while m_axis_tready is held high; six register stages, each with its own valid bit.
// Backpressure stalls only the stages that hold data, so bubbles are absorbed.
// Reset clears all stage valid bits and sets the tolerance register to 0.
module triangle_unit_square_overlap (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // vertex_a_u, vertex_a_v, vertex_b_u, vertex_b_v, vertex_c_u, vertex_c_v
  input  logic [tuso_pkg::DATA_W-1:0] s_axis_tdata,
  // coords_valid
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // overlaps, then zero fill
  output logic [tuso_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                        cfg_wr_en,
  input  logic [tuso_pkg::TOL_W-1:0]  cfg_wr_data
);
  import tuso_pkg::*;

  logic [TOL_W-1:0] overlap_tolerance;
  tri_t             tri_word;
  s2_t              s2_word;
  s4_t              s4_word;
  logic             s2_valid, s2_ready, s4_valid, s4_ready;
  logic             overlaps;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_tolerance <= '0;
    end else if (cfg_wr_en) begin
      overlap_tolerance <= cfg_wr_data;
    end
  end

  always_comb begin
    tri_word.coords_ok = s_axis_tuser;
    tri_word.pu[0]     = s_axis_tdata[0*COORD_W +: COORD_W];
    tri_word.pv[0]     = s_axis_tdata[1*COORD_W +: COORD_W];
    tri_word.pu[1]     = s_axis_tdata[2*COORD_W +: COORD_W];
    tri_word.pv[1]     = s_axis_tdata[3*COORD_W +: COORD_W];
    tri_word.pu[2]     = s_axis_tdata[4*COORD_W +: COORD_W];
    tri_word.pv[2]     = s_axis_tdata[5*COORD_W +: COORD_W];
  end

  tuso_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_word   (tri_word),
    .tol       (overlap_tolerance),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_word  (s2_word)
  );

  tuso_project u_project (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_word   (s2_word),
    .out_valid (s4_valid),
    .out_ready (s4_ready),
    .out_word  (s4_word)
  );

  tuso_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s4_valid),
    .in_ready  (s4_ready),
    .in_word   (s4_word),
    .tol       (overlap_tolerance),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .overlaps  (overlaps)
  );

  assign m_axis_tdata = {{(OUT_W-1){1'b0}}, overlaps};

endmodule
